// ----- sv/scsu_pkg.sv -----
package scsu_pkg;

	localparam int NUM_WIN   = 8;
	localparam int NUM_FIXED = 7;
	localparam int MAX_BYTES = 3;

	typedef logic [15:0] unit_t;
	typedef logic [2:0]  win_idx_t;
	typedef logic [7:0]  byte_t;
	typedef logic [1:0]  byte_cnt_t;

	// One code unit with its lookahead, as taken from the input channel
	typedef struct packed {
		unit_t code_unit;
		unit_t next_unit;
		logic  has_next;
		logic  start_of_string;
	} item_t;

	// Dynamic window state carried from one code unit to the next
	typedef struct packed {
		logic [NUM_WIN-1:0][15:0] bases;
		win_idx_t                 active;
		win_idx_t                 ptr;
	} win_state_t;

	// Encoded bytes for one code unit, byte 0 goes out first
	typedef struct packed {
		logic [MAX_BYTES-1:0][7:0] bytes;
		byte_cnt_t                 count;
	} enc_res_t;

	localparam logic [31:0] LITERAL_MASK    = 32'h0000_2601;
	localparam unit_t       QUOTE_LOW       = 16'h3400;
	localparam unit_t       QUOTE_HIGH      = 16'hDFFF;
	localparam logic [8:0]  HIGH_INDEX_BIAS = 9'h158;
	localparam unit_t       BLOCK_MASK      = 16'hFF80;
	localparam byte_t       TAG_SQU         = 8'h0E;
	localparam byte_t       TAG_SC          = 8'h10;
	localparam byte_t       TAG_SD          = 8'h18;
	localparam byte_t       TAG_SQ          = 8'h01;
	localparam byte_t       FIXED_ID_BASE   = 8'hF9;
	localparam byte_t       OFFSET_BIAS     = 8'h80;

	localparam logic [NUM_WIN-1:0][15:0] DEFAULT_BASES = {
		16'hFF00, 16'h30A0, 16'h3040, 16'h0900,
		16'h0600, 16'h0400, 16'h00C0, 16'h0080
	};

	localparam logic [NUM_WIN-1:0][15:0] STATIC_BASES = {
		16'h3000, 16'h2100, 16'h2080, 16'h2000,
		16'h0300, 16'h0100, 16'h0080, 16'h0000
	};

	localparam logic [NUM_FIXED-1:0][15:0] FIXED_BASES = {
		16'hFF60, 16'h30A0, 16'h3040, 16'h0530,
		16'h0370, 16'h0250, 16'h00C0
	};

	// True when unit lies in the 128-unit window starting at base
	function automatic logic in_window(input unit_t unit, input unit_t base);
		logic [16:0] diff;
		diff = {1'b0, unit} - {1'b0, base};
		return diff[16:7] == '0;
	endfunction

endpackage

// ----- sv/scsu_enc_core.sv -----
module scsu_enc_core import scsu_pkg::*; (
	input  item_t      item,
	input  win_state_t cur,
	output enc_res_t   res,
	output win_state_t nxt
);

	win_state_t          eff;
	unit_t               ch;
	unit_t               nx;
	logic [NUM_WIN-1:0]  stat_hit;
	logic [NUM_WIN-1:0]  dyn_hit;
	logic [NUM_WIN-1:0]  nx_hit;
	logic [NUM_FIXED-1:0] fix_hit;
	win_idx_t            stat_sel;
	win_idx_t            dyn_sel;
	logic [2:0]          fix_sel;
	logic                is_lit;
	logic                is_quote;
	logic                do_redef;
	unit_t               act_diff;
	unit_t               dyn_diff;
	unit_t               stat_diff;
	unit_t               rd_base;
	unit_t               rd_diff;
	byte_t               rd_id;
	logic [8:0]          blk;

	assign ch  = item.code_unit;
	assign nx  = item.next_unit;
	assign blk = ch[15:7];

	// Reload default windows at the start of a string
	always_comb begin
		if (item.start_of_string) begin
			eff.bases  = DEFAULT_BASES;
			eff.active = '0;
			eff.ptr    = '0;
		end else begin
			eff = cur;
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_WIN; i++) begin
			stat_hit[i] = in_window(ch, STATIC_BASES[i]);
			dyn_hit[i]  = in_window(ch, eff.bases[i]);
			nx_hit[i]   = item.has_next && in_window(nx, eff.bases[i]);
		end
		for (int k = 0; k < NUM_FIXED; k++) begin
			fix_hit[k] = in_window(ch, FIXED_BASES[k]);
		end
	end

	// Lowest matching index wins
	always_comb begin
		stat_sel = '0;
		dyn_sel  = '0;
		fix_sel  = '0;
		for (int i = NUM_WIN - 1; i >= 0; i--) begin
			if (stat_hit[i]) stat_sel = 3'(i);
			if (dyn_hit[i]) dyn_sel = 3'(i);
		end
		for (int k = NUM_FIXED - 1; k >= 0; k--) begin
			if (fix_hit[k]) fix_sel = 3'(k);
		end
	end

	assign is_lit   = (blk == '0) && ((ch[6:5] != 2'b00) || LITERAL_MASK[ch[4:0]]);
	assign is_quote = (ch >= QUOTE_LOW) && (ch <= QUOTE_HIGH);

	always_comb begin
		if (fix_hit != '0) begin
			rd_base = FIXED_BASES[fix_sel];
			rd_id   = FIXED_ID_BASE + {5'b0, fix_sel};
		end else if (ch < QUOTE_LOW) begin
			rd_base = ch & BLOCK_MASK;
			rd_id   = blk[7:0];
		end else begin
			rd_base = ch & BLOCK_MASK;
			rd_id   = 8'(blk - HIGH_INDEX_BIAS);
		end
	end

	assign rd_diff   = ch - rd_base;
	assign act_diff  = ch - eff.bases[eff.active];
	assign dyn_diff  = ch - eff.bases[dyn_sel];
	assign stat_diff = ch - STATIC_BASES[stat_sel];

	always_comb begin
		res      = '0;
		nxt      = eff;
		do_redef = 1'b0;
		priority if (is_lit) begin
			res.bytes[0] = ch[7:0];
			res.count    = 2'd1;
		end else if (in_window(ch, eff.bases[eff.active])) begin
			res.bytes[0] = OFFSET_BIAS | {1'b0, act_diff[6:0]};
			res.count    = 2'd1;
		end else if (stat_hit != '0) begin
			if (stat_sel != '0 && item.has_next && nx[15:7] == blk) begin
				do_redef = 1'b1;
			end else begin
				res.bytes[0] = TAG_SQ + {5'b0, stat_sel};
				res.bytes[1] = {1'b0, stat_diff[6:0]};
				res.count    = 2'd2;
			end
		end else if (dyn_hit != '0) begin
			if (nx_hit[dyn_sel]) begin
				res.bytes[0] = TAG_SC + {5'b0, dyn_sel};
				nxt.active   = dyn_sel;
			end else begin
				res.bytes[0] = TAG_SQ + {5'b0, dyn_sel};
			end
			res.bytes[1] = OFFSET_BIAS | {1'b0, dyn_diff[6:0]};
			res.count    = 2'd2;
		end else begin
			do_redef = 1'b1;
		end

		if (do_redef) begin
			res.count = 2'd3;
			if (is_quote) begin
				res.bytes[0] = TAG_SQU;
				res.bytes[1] = ch[15:8];
				res.bytes[2] = ch[7:0];
			end else begin
				res.bytes[0]         = TAG_SD + {5'b0, eff.ptr};
				res.bytes[1]         = rd_id;
				res.bytes[2]         = OFFSET_BIAS | {1'b0, rd_diff[6:0]};
				nxt.bases[eff.ptr]   = rd_base;
				nxt.active           = eff.ptr;
				nxt.ptr              = eff.ptr + 3'd1;
			end
		end
	end

endmodule

// ----- sv/scsu_stream_encoder.sv -----
// SCSU single-byte-mode encoder on stream channels.
// Input channel (s_*): one transaction carries one 16-bit code unit with
// its lookahead unit in s_tdata and two flags in s_tuser. A set
// start_of_string flag reloads the eight default dynamic windows and
// clears the active window and redefinition pointer before that unit.
// Output channel (m_*): one transaction carries one SCSU byte; m_tlast
// marks the final byte produced for a code unit (each unit yields 1 to 3).
// A unit passes the input register, then the result register, whose bytes
// are offered on m_tdata. Throughput: one output byte per cycle while the
// receiver accepts, so the single-byte output channel sets the rate;
// encoding is combinational and the next unit is encoded while the
// previous bytes drain.
// Reset (arst_n low) empties both registers and restores the default
// windows. When the receiver stalls, the current byte holds on m_tdata,
// the next unit waits in the input register and s_tready drops.
module scsu_stream_encoder import scsu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [15:0] code_unit, [31:16] next_unit
	input  logic [1:0]  s_tuser,  // [0] has_next, [1] start_of_string
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // [7:0] out_byte
	output logic        m_tlast   // last_byte
);

	item_t      item_s1;
	logic       valid_s1;
	win_state_t win_q;
	win_state_t win_nxt;
	enc_res_t   enc;
	logic [MAX_BYTES-1:0][7:0] bytes_q;
	byte_cnt_t  cnt_q;
	byte_cnt_t  idx_q;
	logic       res_valid_q;
	logic       res_free;
	logic       load;
	logic       out_xfer;

	scsu_enc_core u_core (
		.item (item_s1),
		.cur  (win_q),
		.res  (enc),
		.nxt  (win_nxt)
	);

	// Result register takes a new unit when empty or its final byte leaves
	assign out_xfer = m_tvalid && m_tready;
	assign res_free = !res_valid_q || (out_xfer && m_tlast);
	assign load     = valid_s1 && res_free;
	assign s_tready = !valid_s1 || load;

	assign m_tvalid = res_valid_q;
	assign m_tdata  = bytes_q[idx_q];
	assign m_tlast  = (idx_q == cnt_q - 2'd1);

	// Input register: hold the unit until the result register frees
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.code_unit       <= s_tdata[15:0];
			item_s1.next_unit       <= s_tdata[31:16];
			item_s1.has_next        <= s_tuser[0];
			item_s1.start_of_string <= s_tuser[1];
		end
	end

	// Window state and result control: advance the state only as a unit is encoded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q  <= 1'b0;
			idx_q        <= '0;
			cnt_q        <= '0;
			win_q.bases  <= DEFAULT_BASES;
			win_q.active <= '0;
			win_q.ptr    <= '0;
		end else if (load) begin
			res_valid_q <= 1'b1;
			idx_q       <= '0;
			cnt_q       <= enc.count;
			win_q       <= win_nxt;
		end else if (out_xfer) begin
			if (m_tlast) begin
				res_valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q <= enc.bytes;
		end
	end

endmodule
